// File: src/sfp_pkg.sv
// Shared types and constants for the serial frame parser with checksum.
// No dependencies; imported by sfp_parser and serial_frame_parser_checksum_core.
package sfp_pkg;

    // Event codes carried in event_res
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_HEADER = 3'd1;
    localparam logic [2:0] EV_DATA   = 3'd2;
    localparam logic [2:0] EV_DONE   = 3'd3;
    localparam logic [2:0] EV_RDREQ  = 3'd4;

    // Header bytes and length bias
    localparam logic [7:0]  HDR0     = 8'hEF;
    localparam logic [7:0]  HDR1     = 8'h02;
    localparam logic [15:0] LEN_BIAS = 16'd3;

    // Frame positions (position counter is 17 bits so it never wraps)
    localparam int          POS_W     = 17;
    localparam logic [16:0] POS_HDR0  = 17'd0;
    localparam logic [16:0] POS_HDR1  = 17'd1;
    localparam logic [16:0] POS_ADDR0 = 17'd2;
    localparam logic [16:0] POS_ADDR3 = 17'd5;
    localparam logic [16:0] POS_SIGN  = 17'd6;
    localparam logic [16:0] POS_LENH  = 17'd7;
    localparam logic [16:0] POS_LENL  = 17'd8;
    localparam logic [16:0] POS_CMD   = 17'd9;
    localparam logic [16:0] POS_DATA  = 17'd10;
    localparam logic [16:0] POS_SUMH  = 17'd10;
    localparam logic [16:0] POS_SUML  = 17'd11;

    // One result beat
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  packet_sign;
        logic [7:0]  command_byte;
        logic [15:0] payload_length;
        logic        checksum_match;
        logic        frame_accepted;
    } t_result;

    // Frame-open address byte for slot 0..3
    function automatic logic [7:0] frame_addr(input logic [1:0] slot);
        logic [7:0] v;
        unique case (slot)
            2'd0:    v = 8'hFF;
            2'd1:    v = 8'hFF;
            2'd2:    v = 8'hCC;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

    // Address-read request byte for slot 0..3
    function automatic logic [7:0] rdreq_addr(input logic [1:0] slot);
        logic [7:0] v;
        unique case (slot)
            2'd0:    v = 8'hFF;
            2'd1:    v = 8'hEE;
            2'd2:    v = 8'hDD;
            default: v = 8'hCC;
        endcase
        return v;
    endfunction

endpackage

// File: src/sfp_parser.sv
// Parser state registers and one-byte step logic: hunt, frame capture, running sum.
// Depends on sfp_pkg for event codes, positions, address tables and t_result.
module sfp_parser
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_check_disable,
    output t_result     o_result
);

    logic [POS_W-1:0] r_position,  n_position;
    logic             r_in_frame,  n_in_frame;
    logic             r_rdreq,     n_rdreq;
    logic [7:0]       r_sign,      n_sign;
    logic [15:0]      r_follow,    n_follow;
    logic [7:0]       r_command,   n_command;
    logic [15:0]      r_rx_sum,    n_rx_sum;
    logic [15:0]      r_run_sum,   n_run_sum;

    logic [15:0]      plen_cur;
    logic [POS_W-1:0] data_end;
    logic [POS_W-1:0] data_off;
    logic             in_addr;
    logic             match;
    logic [2:0]       ev;

    assign plen_cur = r_follow - LEN_BIAS;
    assign data_end = POS_SUMH + {1'b0, plen_cur};
    assign data_off = r_position - POS_DATA;
    assign in_addr  = (r_position >= POS_ADDR0) && (r_position <= POS_ADDR3);

    // Compute next state and event for the byte at the input register
    always_comb begin
        logic [1:0] aslot;
        logic [15:0] full_len;
        logic [15:0] full_sum;
        aslot    = 2'(r_position - POS_ADDR0);
        full_len = {r_follow[15:8], i_byte};
        full_sum = {r_rx_sum[15:8], i_byte};
        n_position = r_position;
        n_in_frame = r_in_frame;
        n_rdreq    = r_rdreq;
        n_sign     = r_sign;
        n_follow   = r_follow;
        n_command  = r_command;
        n_rx_sum   = r_rx_sum;
        n_run_sum  = r_run_sum;
        ev         = EV_NONE;
        match      = 1'b0;
        if (r_in_frame) begin
            priority if (r_position == POS_SIGN) begin
                n_sign     = i_byte;
                n_run_sum  = {8'd0, i_byte};
                n_position = POS_LENH;
                ev         = EV_HEADER;
            end else if (r_position == POS_LENH) begin
                n_follow   = {i_byte, 8'd0};
                n_position = POS_LENL;
                ev         = EV_HEADER;
            end else if (r_position == POS_LENL) begin
                n_follow   = full_len;
                n_run_sum  = r_run_sum + full_len;
                n_position = POS_CMD;
                ev         = EV_HEADER;
            end else if (r_position == POS_CMD) begin
                n_command  = i_byte;
                n_run_sum  = r_run_sum + {8'd0, i_byte};
                n_position = POS_DATA;
                ev         = EV_HEADER;
            end else if (r_position >= POS_DATA && r_position < data_end) begin
                n_run_sum  = r_run_sum + {8'd0, i_byte};
                n_position = r_position + 17'd1;
                ev         = EV_DATA;
            end else if (r_position == data_end) begin
                n_rx_sum   = {i_byte, 8'd0};
                n_position = r_position + 17'd1;
                ev         = EV_HEADER;
            end else if (r_position == data_end + 17'd1) begin
                n_rx_sum   = full_sum;
                match      = (full_sum == r_run_sum);
                n_in_frame = 1'b0;
                n_position = POS_HDR0;
                ev         = EV_DONE;
            end else begin
                ev = EV_NONE;
            end
        end else begin
            // Hunt for header, then one of the two address sequences
            priority if (r_position == POS_HDR0 && i_byte == HDR0) begin
                n_position = POS_HDR1;
                ev         = EV_HEADER;
            end else if (r_position == POS_HDR1 && i_byte == HDR1) begin
                n_position = POS_ADDR0;
                ev         = EV_HEADER;
            end else if (in_addr && i_byte == frame_addr(aslot) && !r_rdreq) begin
                n_position = r_position + 17'd1;
                n_in_frame = (r_position == POS_ADDR3);
                ev         = EV_HEADER;
            end else if (in_addr && i_byte == rdreq_addr(aslot)) begin
                if (r_position == POS_ADDR3) begin
                    n_position = POS_HDR0;
                    n_rdreq    = 1'b0;
                    ev         = EV_RDREQ;
                end else begin
                    n_position = r_position + 17'd1;
                    n_rdreq    = 1'b1;
                    ev         = EV_HEADER;
                end
            end else begin
                n_position = POS_HDR0;
                n_rdreq    = 1'b0;
            end
        end
    end

    // Build the result beat from the post-step values
    always_comb begin
        o_result.event_res      = ev;
        o_result.data_byte      = i_byte;
        o_result.payload_index  = (ev == EV_DATA) ? data_off[15:0] : 16'd0;
        o_result.packet_sign    = n_sign;
        o_result.command_byte   = n_command;
        o_result.payload_length = n_follow - LEN_BIAS;
        o_result.checksum_match = match;
        o_result.frame_accepted = (ev == EV_DONE) && (match || i_check_disable);
    end

    // Advance state when the byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_in_frame <= 1'b0;
            r_rdreq    <= 1'b0;
            r_sign     <= '0;
            r_follow   <= '0;
            r_command  <= '0;
            r_rx_sum   <= '0;
            r_run_sum  <= '0;
        end else if (i_step) begin
            r_position <= n_position;
            r_in_frame <= n_in_frame;
            r_rdreq    <= n_rdreq;
            r_sign     <= n_sign;
            r_follow   <= n_follow;
            r_command  <= n_command;
            r_rx_sum   <= n_rx_sum;
            r_run_sum  <= n_run_sum;
        end
    end

endmodule

// File: src/serial_frame_parser_checksum_core.sv
// Top level of the serial frame parser: input register, parser, result register.
// Depends on sfp_pkg and sfp_parser.
//
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_stall   i_rx_byte
//  out       out  o_out_valid / i_out_stall o_event_res .. o_frame_accepted
//  cfg       in   i_cfg_we                  i_cfg_wdata (check_disable)
//
// One byte per cycle sustained unless i_out_stall holds the result register.
// The parser step is one pass of compare/add logic between the input and result
// registers. Reset is synchronous, active low; check_disable resets to 1.
// A stalled result holds the result register; the input register keeps its
// beat and o_in_stall rises only while both registers are full.
module serial_frame_parser_checksum_core
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_packet_sign,
    output logic [7:0]  o_command_byte,
    output logic [15:0] o_payload_length,
    output logic        o_checksum_match,
    output logic        o_frame_accepted,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_check_disable;
    logic       adv;
    logic       step;
    t_result    n_out;

    // Result register can take a new beat when empty or being drained
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    // Hold the configuration bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_disable <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_disable <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_byte          (r_in_byte),
        .i_check_disable (r_check_disable),
        .o_result        (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_out.event_res;
    assign o_data_byte      = r_out.data_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_packet_sign    = r_out.packet_sign;
    assign o_command_byte   = r_out.command_byte;
    assign o_payload_length = r_out.payload_length;
    assign o_checksum_match = r_out.checksum_match;
    assign o_frame_accepted = r_out.frame_accepted;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_parser_checksum_core: a byte driver and a result monitor
// around a self-contained frame parser predictor. Depends on sfp_pkg and the core RTL.
module tb;
    import sfp_pkg::*;

    localparam logic [31:0] FRAME_ADDR     = 32'hFFFF_CC01;
    localparam logic [31:0] RDREQ_ADDR     = 32'hFFEE_DDCC;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          MAX_PRINTS     = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_data_byte;
    logic [15:0] o_payload_index;
    logic [7:0]  o_packet_sign;
    logic [7:0]  o_command_byte;
    logic [15:0] o_payload_length;
    logic        o_checksum_match;
    logic        o_frame_accepted;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;

    serial_frame_parser_checksum_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_data_byte      (o_data_byte),
        .o_payload_index  (o_payload_index),
        .o_packet_sign    (o_packet_sign),
        .o_command_byte   (o_command_byte),
        .o_payload_length (o_payload_length),
        .o_checksum_match (o_checksum_match),
        .o_frame_accepted (o_frame_accepted),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Bytes waiting to be sent and parser results waiting to come out
    logic [7:0] rx_bytes_q[$];
    t_result    parse_results_q[$];

    // Predictor state
    logic [16:0] fr_pos     = '0;
    logic        fr_open    = 1'b0;
    logic        rdreq_seen = 1'b0;
    logic [7:0]  sign_q     = '0;
    logic [15:0] flen_q     = '0;
    logic [7:0]  cmd_q      = '0;
    logic [15:0] rx_sum_q   = '0;
    logic [15:0] run_sum_q  = '0;
    logic        chk_off    = 1'b1;

    // Run control and counters
    bit gaps_on = 1'b1;
    int mismatches = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int frames_done = 0;
    int frames_rejected = 0;
    int rdreqs_seen = 0;
    int idle_cycles = 0;

    // Advance the parser model by one received byte
    function automatic t_result parse_step(input logic [7:0] b);
        t_result     r;
        logic [15:0] n;
        logic [1:0]  slot;
        int          p;
        r = '0;
        r.data_byte = b;
        n = flen_q - LEN_BIAS;
        p = int'(fr_pos);
        slot = 2'(fr_pos - POS_ADDR0);
        if (fr_open) begin
            if (fr_pos == POS_SIGN) begin
                sign_q = b;
                run_sum_q = {8'h00, b};
                fr_pos = POS_LENH;
                r.event_res = EV_HEADER;
            end else if (fr_pos == POS_LENH) begin
                flen_q = {b, 8'h00};
                fr_pos = POS_LENL;
                r.event_res = EV_HEADER;
            end else if (fr_pos == POS_LENL) begin
                flen_q = {flen_q[15:8], b};
                run_sum_q = run_sum_q + flen_q;
                fr_pos = POS_CMD;
                r.event_res = EV_HEADER;
            end else if (fr_pos == POS_CMD) begin
                cmd_q = b;
                run_sum_q = run_sum_q + {8'h00, b};
                fr_pos = POS_DATA;
                r.event_res = EV_HEADER;
            end else if (p >= 10 && p < 10 + int'(n)) begin
                r.payload_index = 16'(p - 10);
                run_sum_q = run_sum_q + {8'h00, b};
                fr_pos = fr_pos + 17'd1;
                r.event_res = EV_DATA;
            end else if (p == 10 + int'(n)) begin
                rx_sum_q = {b, 8'h00};
                fr_pos = fr_pos + 17'd1;
                r.event_res = EV_HEADER;
            end else if (p == 11 + int'(n)) begin
                rx_sum_q = {rx_sum_q[15:8], b};
                r.checksum_match = (rx_sum_q == run_sum_q);
                r.frame_accepted = r.checksum_match | chk_off;
                fr_open = 1'b0;
                fr_pos = POS_HDR0;
                r.event_res = EV_DONE;
            end
        end else begin
            if (fr_pos == POS_HDR0 && b == HDR0) begin
                fr_pos = POS_HDR1;
                r.event_res = EV_HEADER;
            end else if (fr_pos == POS_HDR1 && b == HDR1) begin
                fr_pos = POS_ADDR0;
                r.event_res = EV_HEADER;
            end else if (p >= 2 && p <= 5 && !rdreq_seen
                         && b == FRAME_ADDR[31 - 8 * slot -: 8]) begin
                fr_pos = fr_pos + 17'd1;
                if (fr_pos == POS_SIGN) fr_open = 1'b1;
                r.event_res = EV_HEADER;
            end else if (p >= 2 && p <= 5 && b == RDREQ_ADDR[31 - 8 * slot -: 8]) begin
                fr_pos = fr_pos + 17'd1;
                rdreq_seen = 1'b1;
                r.event_res = EV_HEADER;
                if (fr_pos == POS_SIGN) begin
                    rdreq_seen = 1'b0;
                    fr_pos = POS_HDR0;
                    r.event_res = EV_RDREQ;
                end
            end else begin
                fr_pos = POS_HDR0;
                rdreq_seen = 1'b0;
            end
        end
        r.packet_sign = sign_q;
        r.command_byte = cmd_q;
        r.payload_length = flen_q - LEN_BIAS;
        return r;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: result %0d %s: got 0x%0h, want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // Push the first k bytes of header + address, k up to 6
    task automatic push_prefix(input logic [31:0] addr, input int k);
        logic [47:0] seq;
        int          j;
        seq = {HDR0, HDR1, addr};
        for (j = 0; j < k; j++) rx_bytes_q.push_back(seq[47 - 8 * j -: 8]);
    endtask

    // Push one complete frame with random sign, command and payload
    task automatic push_frame(input logic [15:0] flen, input bit corrupt);
        logic [7:0]  sign;
        logic [7:0]  cmd;
        logic [7:0]  d;
        logic [15:0] sum;
        logic [15:0] n;
        int          i;
        sign = 8'($urandom);
        cmd = 8'($urandom);
        n = flen - LEN_BIAS;
        sum = {8'h00, sign} + flen + {8'h00, cmd};
        push_prefix(FRAME_ADDR, 6);
        rx_bytes_q.push_back(sign);
        rx_bytes_q.push_back(flen[15:8]);
        rx_bytes_q.push_back(flen[7:0]);
        rx_bytes_q.push_back(cmd);
        for (i = 0; i < int'(n); i++) begin
            d = 8'($urandom);
            sum = sum + {8'h00, d};
            rx_bytes_q.push_back(d);
        end
        if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
        rx_bytes_q.push_back(sum[15:8]);
        rx_bytes_q.push_back(sum[7:0]);
    endtask

    // Push a frame head and the first k payload bytes; the frame stays open
    task automatic push_frame_head(input logic [15:0] flen, input int k);
        int i;
        push_prefix(FRAME_ADDR, 6);
        rx_bytes_q.push_back(8'($urandom));
        rx_bytes_q.push_back(flen[15:8]);
        rx_bytes_q.push_back(flen[7:0]);
        rx_bytes_q.push_back(8'($urandom));
        for (i = 0; i < k; i++) rx_bytes_q.push_back(8'($urandom));
    endtask

    // Random mix of frames (some corrupted), read requests, cut-off headers and noise
    task automatic fill_random(input int count);
        int start;
        int pick;
        int j;
        logic [15:0] flen;
        @(negedge i_clk);
        start = rx_bytes_q.size();
        while (rx_bytes_q.size() - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 7) == 0) flen = 16'($urandom_range(3, 40));
                else flen = 16'($urandom_range(3, 15));
                push_frame(flen, $urandom_range(0, 3) == 0);
            end else if (pick < 72) begin
                push_prefix(RDREQ_ADDR, 6);
            end else if (pick < 88) begin
                push_prefix($urandom_range(0, 1) ? RDREQ_ADDR : FRAME_ADDR,
                            $urandom_range(1, 5));
                rx_bytes_q.push_back(8'($urandom));
            end else begin
                for (j = $urandom_range(1, 4); j > 0; j--)
                    rx_bytes_q.push_back(8'($urandom));
            end
        end
    endtask

    // Wait until every byte is sent and every result checked, then let the pipe settle
    task automatic wait_drained;
        @(negedge i_clk);
        while (rx_bytes_q.size() != 0 || i_in_valid || parse_results_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write check_disable while the block is idle
    task automatic write_check_off(input logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        chk_off = v;
    endtask

    // Sender: hold a stalled beat, otherwise idle in bursts or send the next byte
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic       nv;
        logic [7:0] nb;
        nv = 1'b0;
        nb = i_rx_byte;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_results_q.push_back(parse_step(i_rx_byte));
                bytes_in++;
            end
            if (i_in_valid && o_in_stall) begin
                nv = 1'b1;
            end else if (gaps_on && gap_left > 0) begin
                gap_left--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
            end else if (rx_bytes_q.size() != 0) begin
                nb = rx_bytes_q.pop_front();
                nv = 1'b1;
            end
        end
        i_in_valid <= nv;
        i_rx_byte <= nb;
    end

    // Receiver: check each result beat, stall in bursts, and hold off long twice
    int stall_left = 0;
    int hold_left = 0;
    int hold_mark = 150;
    always @(posedge i_clk) begin
        t_result want;
        logic    ns;
        ns = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (parse_results_q.size() == 0) begin
                report_mismatch("unexpected beat, event", o_event_res, 0);
            end else begin
                want = parse_results_q.pop_front();
                check_field("event_res", o_event_res, want.event_res);
                check_field("data_byte", o_data_byte, want.data_byte);
                check_field("payload_index", o_payload_index, want.payload_index);
                check_field("packet_sign", o_packet_sign, want.packet_sign);
                check_field("command_byte", o_command_byte, want.command_byte);
                check_field("payload_length", o_payload_length, want.payload_length);
                check_field("checksum_match", o_checksum_match, want.checksum_match);
                check_field("frame_accepted", o_frame_accepted, want.frame_accepted);
                if (want.event_res == EV_DONE) begin
                    frames_done++;
                    if (!want.frame_accepted) frames_rejected++;
                end
                if (want.event_res == EV_RDREQ) rdreqs_seen++;
            end
        end
        if (gaps_on && hold_left == 0 && hold_mark != 0 && results_seen >= hold_mark) begin
            hold_left = HOLD_CYCLES;
            hold_mark = (hold_mark < 500) ? hold_mark + 400 : 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (!gaps_on) begin
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            ns = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            ns = 1'b1;
        end
        i_out_stall <= ns;
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("[serial_frame_parser_checksum_core] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, a mismatched start byte, a read request,
        // a read request broken by a frame byte, and a frame with empty payload
        @(negedge i_clk);
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'hFF);
        rx_bytes_q.push_back(HDR0);
        rx_bytes_q.push_back(HDR0);
        rx_bytes_q.push_back(HDR1);
        push_prefix(RDREQ_ADDR, 6);
        push_prefix(RDREQ_ADDR, 4);
        rx_bytes_q.push_back(8'hCC);
        push_frame(16'd3, 1'b1);
        fill_random(300);
        wait_drained;

        // Checking enabled
        write_check_off(1'b0);
        fill_random(300);
        wait_drained;

        write_check_off(1'b1);
        fill_random(250);
        wait_drained;

        // No idling: more traffic, then end inside a frame whose length wraps below three
        write_check_off(1'b0);
        gaps_on = 1'b0;
        fill_random(250);
        push_frame_head(16'd2, 24);
        wait_drained;
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d results: %0d frames (%0d rejected),",
                 bytes_in, results_seen, frames_done, frames_rejected);
        $display("%0d address-read requests, with and without checksum enforcement.",
                 rdreqs_seen);
        if (mismatches == 0)
            $display("[serial_frame_parser_checksum_core] OK");
        else
            $display("[serial_frame_parser_checksum_core] ERROR");
        $finish;
    end

endmodule
